[rtl/drive_command_frame_encoder_core_macros.svh]
// Assertion macros shared by the frame encoder RTL.
// Included by the top level only; no other dependencies.
`ifndef DRIVE_COMMAND_FRAME_ENCODER_CORE_MACROS_SVH
`define DRIVE_COMMAND_FRAME_ENCODER_CORE_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define DCFE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Overlapping implication, checked outside reset.
`define DCFE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dcfe_pkg.sv]
// Shared types, constants and the CRC step for the drive command frame encoder.
// No dependencies.
package dcfe_pkg;

    localparam int VALUE_LIMIT_DEF = 1000;

    localparam int PULSE_W   = 12;
    localparam int GAIN_W    = 12;
    localparam int FLAG_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int CRC_W     = 16;
    localparam int WORD_W    = 16;   // speed/steer go out as 16-bit words
    localparam int FRAC_W    = 8;    // Q4.8 gain
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 3;
    localparam int MAP_OFFSET = 3000;

    // Power of two, pointers wrap naturally.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_BITS  = 2'd1;

    localparam logic signed [GAIN_W-1:0] GAIN_RST = 12'sd256;
    localparam logic [FLAG_W-1:0]        FLAG_RST = 8'h07;

    // Frame byte positions.
    localparam logic [POS_W-1:0] BYTE_SOF   = 3'd0;
    localparam logic [POS_W-1:0] BYTE_SP_HI = 3'd1;
    localparam logic [POS_W-1:0] BYTE_SP_LO = 3'd2;
    localparam logic [POS_W-1:0] BYTE_ST_HI = 3'd3;
    localparam logic [POS_W-1:0] BYTE_ST_LO = 3'd4;
    localparam logic [POS_W-1:0] BYTE_FLAGS = 3'd5;
    localparam logic [POS_W-1:0] BYTE_CRC   = 3'd6;
    localparam logic [POS_W-1:0] BYTE_EOF   = 3'd7;

    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;

    typedef struct packed {
        logic [PULSE_W-1:0] speed_pulse;
        logic [PULSE_W-1:0] steer_pulse;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // CRC-16, MSB first, one byte.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[rtl/dcfe_front.sv]
// Front end: accepts pulse pairs, maps, scales, clamps and pushes commands.
// Depends on dcfe_pkg.
module dcfe_front #(
    parameter int VALUE_LIMIT = dcfe_pkg::VALUE_LIMIT_DEF,
    parameter int VAL_W       = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dcfe_pkg::t_in_item                  i_in_data,
    input  logic signed [dcfe_pkg::GAIN_W-1:0]  i_speed_gain,
    input  dcfe_pkg::t_q_stat                   i_q_stat,
    output logic                                o_push,
    output logic [2*VAL_W-1:0]                  o_push_data
);
    import dcfe_pkg::*;

    localparam int SP_W   = PULSE_W + 2;
    localparam int PROD_W = SP_W + GAIN_W;
    localparam int CL_W   = PROD_W - FRAC_W;
    localparam logic signed [CL_W-1:0] LIM  = CL_W'(VALUE_LIMIT);
    localparam logic signed [CL_W-1:0] NLIM = -LIM;

    logic                     r_vld, n_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SP_W-1:0]   r_st;

    logic signed [SP_W-1:0]   w_sp, w_st;
    logic signed [PROD_W-1:0] w_prod, w_sum;
    logic signed [CL_W-1:0]   w_q, w_st_x, w_sp_c, w_st_c, w_st_f;
    logic                     w_accept, w_push;

    assign w_sp = $signed({1'b0, i_in_data.speed_pulse, 1'b0}) - SP_W'(MAP_OFFSET);
    assign w_st = $signed({1'b0, i_in_data.steer_pulse, 1'b0}) - SP_W'(MAP_OFFSET);
    assign w_prod = PROD_W'(w_sp) * PROD_W'(i_speed_gain);

    assign w_push     = r_vld && !i_q_stat.full;
    assign o_in_ready = !r_vld || w_push;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_vld = r_vld;
        if (w_accept) begin
            n_vld = 1'b1;
        end else if (w_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod <= w_prod;
            r_st   <= w_st;
        end
    end

    // Divide by 256 toward zero: bias negatives before the shift.
    assign w_sum = r_prod + (r_prod[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : '0);
    assign w_q   = w_sum[PROD_W-1:FRAC_W];
    assign w_st_x = CL_W'(r_st);

    always_comb begin
        if (w_q > LIM) begin
            w_sp_c = LIM;
        end else if (w_q < NLIM) begin
            w_sp_c = NLIM;
        end else begin
            w_sp_c = w_q;
        end
        if (w_st_x > LIM) begin
            w_st_c = LIM;
        end else if (w_st_x < NLIM) begin
            w_st_c = NLIM;
        end else begin
            w_st_c = w_st_x;
        end
        // Reversing flips steer.
        w_st_f = w_sp_c[CL_W-1] ? -w_st_c : w_st_c;
    end

    assign o_push      = w_push;
    assign o_push_data = {VAL_W'(w_sp_c), VAL_W'(w_st_f)};

endmodule

[rtl/dcfe_queue.sv]
// Short command queue between front and back end.
// Depends on dcfe_pkg.
module dcfe_queue #(
    parameter int DATA_W = 22
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [DATA_W-1:0]  i_wdata,
    input  logic               i_pop,
    output logic [DATA_W-1:0]  o_rdata,
    output dcfe_pkg::t_q_stat  o_stat
);
    import dcfe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr, r_rptr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

[rtl/dcfe_back.sv]
// Back end: serializes one queued command into an eight-byte frame with CRC.
// Depends on dcfe_pkg.
module dcfe_back #(
    parameter int VAL_W = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [2*VAL_W-1:0]             i_q_data,
    input  dcfe_pkg::t_q_stat              i_q_stat,
    output logic                           o_pop,
    input  logic [dcfe_pkg::FLAG_W-1:0]    i_flag_bits,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dcfe_pkg::t_out_item            o_out_data
);
    import dcfe_pkg::*;

    logic                     r_out_vld;
    logic [BYTE_W-1:0]        r_out_byte;
    logic                     r_out_last;
    logic [POS_W-1:0]         r_pos;
    logic [CRC_W-1:0]         r_crc;

    logic signed [VAL_W-1:0]  w_sp, w_st;
    logic signed [WORD_W-1:0] w_sp16, w_st16;
    logic [BYTE_W-1:0]        w_byte;
    logic [CRC_W-1:0]         w_crc_in, n_crc;
    logic                     w_load;

    assign w_sp   = i_q_data[2*VAL_W-1:VAL_W];
    assign w_st   = i_q_data[VAL_W-1:0];
    assign w_sp16 = WORD_W'(w_sp);
    assign w_st16 = WORD_W'(w_st);

    assign w_load = !i_q_stat.empty && (!r_out_vld || i_out_ready);
    assign o_pop  = w_load && (r_pos == BYTE_EOF);

    always_comb begin
        unique case (r_pos)
            BYTE_SOF:   w_byte = CHAR_SLASH;
            BYTE_SP_HI: w_byte = w_sp16[WORD_W-1:BYTE_W];
            BYTE_SP_LO: w_byte = w_sp16[BYTE_W-1:0];
            BYTE_ST_HI: w_byte = w_st16[WORD_W-1:BYTE_W];
            BYTE_ST_LO: w_byte = w_st16[BYTE_W-1:0];
            BYTE_FLAGS: w_byte = i_flag_bits;
            BYTE_CRC:   w_byte = r_crc[CRC_W-1:BYTE_W];
            BYTE_EOF:   w_byte = CHAR_NL;
            default:    w_byte = CHAR_NL;
        endcase
    end

    assign w_crc_in = (r_pos == BYTE_SOF) ? '0 : r_crc;
    assign n_crc    = crc_byte(w_crc_in, w_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_pos     <= BYTE_SOF;
            r_crc     <= '0;
        end else begin
            if (w_load) begin
                r_out_vld <= 1'b1;
                r_pos     <= r_pos + POS_W'(1);
                if (r_pos < BYTE_CRC) begin
                    r_crc <= n_crc;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte <= w_byte;
            r_out_last <= (r_pos == BYTE_EOF);
        end
    end

    assign o_out_valid          = r_out_vld;
    assign o_out_data.out_byte  = r_out_byte;
    assign o_out_data.last_byte = r_out_last;

endmodule

[rtl/drive_command_frame_encoder_core.sv]
// Drive command frame encoder, top level: config registers, front, queue, back.
// Depends on dcfe_pkg, dcfe_front, dcfe_queue, dcfe_back and the macros header.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_data): one beat carries a speed
//   and a steer pulse width. Output channel (o_out_valid/i_out_ready,
//   o_out_data): eight beats per input beat, '/', speed hi/lo, steer hi/lo,
//   flags, CRC high byte, '\n'; last_byte marks the newline beat.
//   Config: i_cfg_we writes i_cfg_wdata into register i_cfg_idx (0 speed
//   gain, 1 flag byte); other indexes are dropped. Write only while idle.
// Path: an input beat is registered in the front (one multiply stage), is
//   written to the queue (one queue write), then loaded into the back end's
//   byte-wide output register, which sets the rate: one byte per cycle while
//   the receiver is ready. The front takes items back to back until the
//   queue (QUEUE_DEPTH commands) plus its own stage are full.
// Reset: synchronous, active low; gain returns to 1.0 (256), flags to 0x07,
//   queue and frame position clear.
// Receiver stall: the output byte holds; the back end stops, the queue fills,
//   then o_in_ready drops. No beat is lost or repeated.
`include "drive_command_frame_encoder_core_macros.svh"

module drive_command_frame_encoder_core #(
    parameter int VALUE_LIMIT = dcfe_pkg::VALUE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  dcfe_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output dcfe_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [dcfe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dcfe_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import dcfe_pkg::*;

    // Signed width that holds +/-VALUE_LIMIT.
    localparam int VAL_W = $clog2(VALUE_LIMIT + 1) + 1;

    logic signed [GAIN_W-1:0] r_speed_gain;
    logic [FLAG_W-1:0]        r_flag_bits;

    logic                     w_push, w_pop;
    logic [2*VAL_W-1:0]       w_push_data, w_q_data;
    t_q_stat                  w_q_stat;

    // Config registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_gain <= GAIN_RST;
            r_flag_bits  <= FLAG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPEED_GAIN: r_speed_gain <= i_cfg_wdata[GAIN_W-1:0];
                CFG_FLAG_BITS:  r_flag_bits  <= i_cfg_wdata[FLAG_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: map, multiply by gain, clamp, steer flip.
    dcfe_front #(
        .VALUE_LIMIT (VALUE_LIMIT),
        .VAL_W       (VAL_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_speed_gain (r_speed_gain),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    // Command queue decouples the two halves.
    dcfe_queue #(
        .DATA_W (2*VAL_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_data),
        .i_pop   (w_pop),
        .o_rdata (w_q_data),
        .o_stat  (w_q_stat)
    );

    // Back: byte serializer with running CRC.
    dcfe_back #(
        .VAL_W (VAL_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (w_q_data),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .i_flag_bits (r_flag_bits),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Checks.
    `DCFE_ASSERT(a_q_stat_sane, i_clk, i_rst_n, !(w_q_stat.full && w_q_stat.empty), "queue full and empty")
    `DCFE_ASSERT_IMPL(a_last_is_nl, i_clk, i_rst_n, o_out_valid && o_out_data.last_byte, o_out_data.out_byte == CHAR_NL, "last beat is not newline")
    `DCFE_ASSERT_NEXT(a_sof_after_eof, i_clk, i_rst_n, o_out_valid && i_out_ready && o_out_data.last_byte, !o_out_valid || o_out_data.out_byte == CHAR_SLASH, "frame does not start with slash")
    `DCFE_ASSERT_IMPL(a_pop_on_eof, i_clk, i_rst_n, w_pop, !w_q_stat.empty, "pop from empty queue")

endmodule

[tb/drive_command_frame_encoder_core_test.sv]
// Self-checking testbench for drive_command_frame_encoder_core.
// Depends on dcfe_pkg and the RTL top level; it holds its own frame encoder
// model and checks every output beat against it.
module drive_command_frame_encoder_core_test;
    import dcfe_pkg::*;

    localparam int FRAME_BEATS = 8;
    localparam int CLAMP       = VALUE_LIMIT_DEF;
    localparam int DRAIN_TAIL  = 16;        // slack after the last owed beat
    localparam int CYCLE_LIMIT = 800_000;   // worst case random stalls, times ~5
    localparam int MAX_LINES   = 40;        // mismatch lines printed

    // Indexes with no register behind them; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    drive_command_frame_encoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Model copy of the two registers, tracked from the write port.
    logic signed [GAIN_W-1:0] model_gain;
    logic [FLAG_W-1:0]        model_flags;

    // Beats still owed by the block, oldest first.
    t_out_item pending_beats[$];

    // Idle control shared by the sender, the receiver and the tests.
    bit tx_gaps     = 1'b1;
    bit rx_gaps     = 1'b1;
    int rx_hold_len = 0;

    int err_count     = 0;
    int cmds_accepted = 0;
    int beats_checked = 0;
    int cfg_writes    = 0;
    int cycle_cnt     = 0;

    t_out_item  want_beat;
    t_out_item  new_beat;
    logic [63:0] frame_word;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Frame model
    // ------------------------------------------------------------------

    // CRC-16, polynomial 0x1021, MSB first, one byte folded in.
    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] acc;
        acc = crc_in ^ {data, 8'h00};
        for (int b = 0; b < BYTE_W; b++) begin
            if (acc[CRC_W-1])
                acc = (acc << 1) ^ CRC_POLY;
            else
                acc = acc << 1;
        end
        return acc;
    endfunction

    function automatic int clamp_drive(input int v);
        if (v > CLAMP)  return CLAMP;
        if (v < -CLAMP) return -CLAMP;
        return v;
    endfunction

    // Whole frame for one command, byte 0 in the top eight bits.
    function automatic logic [63:0] encode_frame(input logic [PULSE_W-1:0] speed_p,
                                                 input logic [PULSE_W-1:0] steer_p,
                                                 input logic signed [GAIN_W-1:0] gain,
                                                 input logic [FLAG_W-1:0] flags);
        int                speed;
        int                steer;
        int                scaled;
        logic [WORD_W-1:0] speed_w;
        logic [WORD_W-1:0] steer_w;
        logic [47:0]       head;
        logic [CRC_W-1:0]  crc;
        speed  = 2 * int'(speed_p) - MAP_OFFSET;
        steer  = 2 * int'(steer_p) - MAP_OFFSET;
        scaled = speed * int'(gain);
        speed  = clamp_drive(scaled / 256);   // SV division truncates toward zero
        steer  = clamp_drive(steer);
        if (speed < 0)
            steer = -steer;                   // reversing flips the steer sense
        speed_w = speed[WORD_W-1:0];
        steer_w = steer[WORD_W-1:0];
        head    = {CHAR_SLASH, speed_w, steer_w, flags};
        crc     = '0;
        for (int i = 0; i < 6; i++)
            crc = crc16_step(crc, head[47 - 8*i -: 8]);
        return {head, crc[CRC_W-1 -: 8], CHAR_NL};
    endfunction

    // ------------------------------------------------------------------
    // Input side monitor: register writes and accepted command beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_gain  <= GAIN_RST;
            model_flags <= FLAG_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPEED_GAIN: model_gain  <= i_cfg_wdata[GAIN_W-1:0];
                    CFG_FLAG_BITS:  model_flags <= i_cfg_wdata[FLAG_W-1:0];
                    default: ;   // spare index, dropped
                endcase
            end
            // Registers only change while idle, so the current copy applies.
            if (i_in_valid && o_in_ready) begin
                frame_word = encode_frame(i_in_data.speed_pulse, i_in_data.steer_pulse,
                                          model_gain, model_flags);
                for (int i = 0; i < FRAME_BEATS; i++) begin
                    new_beat.out_byte  = frame_word[63 - 8*i -: 8];
                    new_beat.last_byte = (i == FRAME_BEATS - 1);
                    pending_beats.push_back(new_beat);
                end
                cmds_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: every accepted beat against the oldest one owed
    // ------------------------------------------------------------------
    task automatic report_fail(input string msg);
        err_count++;
        if (err_count <= MAX_LINES)
            $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_beats.size() == 0) begin
                report_fail($sformatf("beat 0x%02h with nothing owed", o_out_data.out_byte));
            end else begin
                want_beat = pending_beats.pop_front();
                if (o_out_data.out_byte !== want_beat.out_byte)
                    report_fail($sformatf("beat %0d out_byte 0x%02h, want 0x%02h",
                                          beats_checked, o_out_data.out_byte,
                                          want_beat.out_byte));
                if (o_out_data.last_byte !== want_beat.last_byte)
                    report_fail($sformatf("beat %0d last_byte %0b, want %0b",
                                          beats_checked, o_out_data.last_byte,
                                          want_beat.last_byte));
                beats_checked++;
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still owed",
                     cycle_cnt, pending_beats.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver pacing. A requested hold-off drops ready for a counted stretch.
    initial begin : rx_pacer
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                n           = rx_hold_len;
                rx_hold_len = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (!rx_gaps) begin
                i_out_ready <= 1'b1;
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    repeat (n - 1) @(posedge i_clk);
                end
            end
        end
    end

    // One command beat. Entered and left just after a rising edge; valid is
    // left high on return so the next call can continue without a bubble.
    task automatic send_cmd(input logic [PULSE_W-1:0] speed_p,
                            input logic [PULSE_W-1:0] steer_p);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid            <= 1'b1;
        i_in_data.speed_pulse <= speed_p;
        i_in_data.steer_pulse <= steer_p;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop offering and wait until every owed beat has come out.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);   // lets the monitor log the last accepted beat
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Call only while idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    // Pulse widths: mostly nominal, some near center, near the clamp, full range.
    function automatic logic [PULSE_W-1:0] rand_pulse();
        int r;
        r = $urandom_range(99);
        if (r < 55) return PULSE_W'($urandom_range(1000, 2000));
        if (r < 70) return PULSE_W'($urandom_range(1490, 1510));
        if (r < 82) begin
            if ($urandom_range(1) == 1)
                return PULSE_W'($urandom_range(990, 1010));
            return PULSE_W'($urandom_range(1990, 2010));
        end
        return PULSE_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [CFG_W-1:0] rand_gain();
        int r;
        r = $urandom_range(99);
        if (r < 25) begin
            case ($urandom_range(3))
                0:       return 12'h800;   // most negative
                1:       return 12'h7FF;   // most positive
                2:       return 12'h000;
                default: return 12'h100;   // unity
            endcase
        end
        if (r < 70) return CFG_W'($urandom_range(64, 768));
        return CFG_W'($urandom_range(0, 4095));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset gain and flags, nominal stick positions.
    task automatic test_reset_defaults();
        send_cmd(12'd1500, 12'd1500);   // centered
        send_cmd(12'd2000, 12'd2000);   // full forward, full right
        send_cmd(12'd1000, 12'd1000);   // reverse flips steer
        send_cmd(12'd1000, 12'd2000);
        send_cmd(12'd2000, 12'd1000);
        send_cmd(12'd1499, 12'd1501);   // barely negative speed
        wait_drain();
    endtask

    // Pulses far outside the nominal range get mapped and clamped.
    task automatic test_pulse_extremes();
        send_cmd(12'd0,    12'd0);
        send_cmd(12'd4095, 12'd4095);
        send_cmd(12'd0,    12'd4095);
        send_cmd(12'd4095, 12'd0);
        send_cmd(12'd2501, 12'd499);
        wait_drain();
    endtask

    // Gain and flag extremes, truncation toward zero, dropped writes.
    task automatic test_gain_and_flags();
        write_reg(CFG_SPEED_GAIN, 12'h800);          // -8.0, flips speed sign
        write_reg(CFG_FLAG_BITS,  12'h000);
        send_cmd(12'd2000, 12'd1500);
        send_cmd(12'd1000, 12'd1700);
        send_cmd(12'd1510, 12'd1800);
        wait_drain();
        write_reg(CFG_SPEED_GAIN, 12'h7FF);          // just under +8.0
        write_reg(CFG_FLAG_BITS,  12'h0FF);
        send_cmd(12'd1501, 12'd1200);
        send_cmd(12'd1490, 12'd1600);
        wait_drain();
        write_reg(CFG_SPEED_GAIN, 12'h000);          // speed forced to zero
        send_cmd(12'd4095, 12'd1800);
        wait_drain();
        write_reg(CFG_SPEED_GAIN, 12'h001);          // -2/256 truncates to zero
        send_cmd(12'd1499, 12'd1300);
        wait_drain();
        write_reg(CFG_SPEED_GAIN, 12'hFFF);          // -1/256, same from the other side
        write_reg(CFG_FLAG_BITS,  12'hA5C);          // bits above the byte dropped
        send_cmd(12'd1501, 12'd1300);
        send_cmd(12'd0,    12'd2200);
        wait_drain();
        write_reg(CFG_SPARE_A, 12'h000);             // no register here
        write_reg(CFG_SPARE_B, 12'hFFF);
        send_cmd(12'd1800, 12'd1100);
        wait_drain();
    endtask

    // Random register settings, random commands with random idling.
    task automatic test_random_traffic(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            write_reg(CFG_SPEED_GAIN, rand_gain());
            write_reg(CFG_FLAG_BITS,  CFG_W'($urandom_range(0, 4095)));
            if ($urandom_range(3) == 0)
                write_reg(($urandom_range(1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_W'($urandom_range(0, 4095)));
            for (int i = 0; i < per_phase; i++)
                send_cmd(rand_pulse(), rand_pulse());
            wait_drain();
        end
    endtask

    // Receiver holds off long enough for the queue to fill and stall the
    // input; sender keeps offering beats throughout.
    task automatic test_receiver_holdoff();
        write_reg(CFG_SPEED_GAIN, 12'h180);   // 1.5
        tx_gaps     = 1'b0;
        rx_hold_len = 300;
        for (int i = 0; i < 24; i++)
            send_cmd(rand_pulse(), rand_pulse());
        tx_gaps = 1'b1;
        wait_drain();                          // sender pauses until all came out
        for (int i = 0; i < 10; i++)
            send_cmd(rand_pulse(), rand_pulse());
        wait_drain();
    endtask

    // No idling on either side: sustained one command per frame time.
    task automatic test_full_rate();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        for (int i = 0; i < 40; i++)
            send_cmd(rand_pulse(), rand_pulse());
        wait_drain();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_pulse_extremes();
        test_gain_and_flags();
        test_random_traffic(4, 38);
        test_receiver_holdoff();
        test_random_traffic(4, 38);
        test_full_rate();
        wait_drain();

        if (pending_beats.size() != 0)
            report_fail($sformatf("%0d beats never came out", pending_beats.size()));
        $display("Run covered %0d commands and %0d frame beats across %0d register writes,",
                 cmds_accepted, beats_checked, cfg_writes);
        $display("with gain/flag extremes, a long receiver hold-off and a gap-free stretch.");
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", err_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
